// ----- rtl/rmvm_pkg.sv -----
// Shared types and constants for the running mean, variance and maximum block.
// Used by rmvm_ctrl, rmvm_core and running_mean_variance_max; no dependencies.
`default_nettype none

package rmvm_pkg;

  // Default widths of the count and sample fields.
  localparam int COUNT_WIDTH_DEF  = 24;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Fixed widths of the variance (Q16.16) and the deviation (Q8.8).
  localparam int VAR_WIDTH  = 32;
  localparam int DEV_WIDTH  = 16;

  // One root bit is found per square root step.
  localparam int SQRT_STEPS = 16;

  // Sequencer states, in the order an item normally walks through them.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_ABS,
    ST_DIV,
    ST_MEAN,
    ST_ADJ,
    ST_DIFF2,
    ST_ABS2,
    ST_MUL,
    ST_CMP,
    ST_NEG,
    ST_DIV2,
    ST_VAR,
    ST_SQRT,
    ST_DONE
  } rmvm_state_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    rmvm_state_t state;
    logic        load;
    logic        commit;
    logic        clear;
  } rmvm_ctl_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic add_neg;
    logic n_one;
  } rmvm_sts_t;

endpackage

`default_nettype wire

// ----- rtl/running_mean_variance_max.sv -----
// Running count, mean, variance, standard deviation and maximum of a stream.
// Top level; depends on rmvm_pkg, rmvm_ctrl and rmvm_core.
//
// Each input item carries a signed Q8.8 sample in in_tdata and a mode bit in
// in_tuser. Mode 0 adds the sample to the statistics; mode 1 clears them.
// Every input item yields exactly one result item that carries the statistics
// after it: count, mean, unbiased variance, its integer square root and the
// peak, which never drops below zero.
// The mean and variance arithmetic runs through one shared adder under a small
// sequencer: a restoring divider for the mean, a shift-and-add square, a
// restoring divider for the variance step and a digit-by-digit square root, one
// bit per cycle. out_tvalid rises with the commit that ends a full update, with an
// extra negation step when the variance shrinks. The first sample after reset
// or a clear skips the variance and root steps, and a clear goes straight to
// the commit. in_tready is high only while the sequencer is idle, which it
// reaches in the cycle after a commit, so items are taken one at a time and a
// new item is not taken until the last one is committed.
// The statistics registers double as the output register. When the receiver
// stalls, the finished result holds on out_tdata and the next item may still
// be accepted and worked on; it is committed only once the old one is taken.
// Reset is synchronous and active low; it clears all statistics to zero.
`default_nettype none

module running_mean_variance_max #(
  parameter int COUNT_WIDTH  = rmvm_pkg::COUNT_WIDTH_DEF,
  parameter int SAMPLE_WIDTH = rmvm_pkg::SAMPLE_WIDTH_DEF,
  localparam int IN_W        = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_RAW     = COUNT_WIDTH + SAMPLE_WIDTH + rmvm_pkg::VAR_WIDTH
                               + rmvm_pkg::DEV_WIDTH + SAMPLE_WIDTH - 1,
  localparam int OUT_W       = ((OUT_RAW + 7) / 8) * 8
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  input  wire [IN_W-1:0]   in_tdata,   // sample
  input  wire              in_tuser,   // mode
  output logic             out_tvalid,
  input  wire              out_tready,
  output logic [OUT_W-1:0] out_tdata   // sample_count, running_mean,
                                       // running_variance, std_deviation,
                                       // peak_value
);

  rmvm_pkg::rmvm_ctl_t ctl;
  rmvm_pkg::rmvm_sts_t sts;

  logic                              out_valid_r, out_valid_nxt;
  logic                              out_free;
  logic [COUNT_WIDTH-1:0]            sample_count;
  logic signed [SAMPLE_WIDTH-1:0]    running_mean;
  logic [rmvm_pkg::VAR_WIDTH-1:0]    running_variance;
  logic [rmvm_pkg::DEV_WIDTH-1:0]    std_deviation;
  logic [SAMPLE_WIDTH-2:0]           peak_value;

  // A new result may be committed when the output is empty or being taken.
  assign out_free = !out_valid_r || out_tready;

  rmvm_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_mode (in_tuser),
    .out_free(out_free),
    .sts     (sts),
    .ctl     (ctl),
    .in_ready(in_tready)
  );

  rmvm_core #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sample          (in_tdata[SAMPLE_WIDTH-1:0]),
    .sts             (sts),
    .sample_count    (sample_count),
    .running_mean    (running_mean),
    .running_variance(running_variance),
    .std_deviation   (std_deviation),
    .peak_value      (peak_value)
  );

  // The valid flag rises on a commit and falls once the item is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({peak_value, std_deviation, running_variance,
                              running_mean, sample_count});

endmodule

`default_nettype wire

// ----- rtl/rmvm_ctrl.sv -----
// Sequencer for the running statistics block: state machine and step counter.
// Depends on rmvm_pkg for the state type and the control and status structs.
`default_nettype none

module rmvm_ctrl #(
  parameter int COUNT_WIDTH  = rmvm_pkg::COUNT_WIDTH_DEF,
  parameter int SAMPLE_WIDTH = rmvm_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_mode,
  input  wire                 out_free,
  input  rmvm_pkg::rmvm_sts_t sts,
  output rmvm_pkg::rmvm_ctl_t ctl,
  output logic                in_ready
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int VW   = rmvm_pkg::VAR_WIDTH;
  localparam int DW   = (2 * SW > VW) ? 2 * SW : VW;
  localparam int K1   = SW + 1;
  localparam int CNTW = $clog2(DW);

  rmvm_pkg::rmvm_state_t state_r, state_nxt;
  logic [CNTW-1:0]       cnt_r, cnt_nxt;
  logic                  clr_r, clr_nxt;

  // Next state and step count.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    clr_nxt   = clr_r;
    case (state_r)
      rmvm_pkg::ST_IDLE: begin
        if (in_valid) begin
          clr_nxt   = in_mode;
          state_nxt = in_mode ? rmvm_pkg::ST_DONE : rmvm_pkg::ST_DIFF;
        end
      end
      rmvm_pkg::ST_DIFF: state_nxt = rmvm_pkg::ST_ABS;
      rmvm_pkg::ST_ABS: begin
        cnt_nxt   = CNTW'(K1 - 1);
        state_nxt = rmvm_pkg::ST_DIV;
      end
      rmvm_pkg::ST_DIV: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = rmvm_pkg::ST_MEAN;
      end
      rmvm_pkg::ST_MEAN: state_nxt = rmvm_pkg::ST_ADJ;
      rmvm_pkg::ST_ADJ: begin
        state_nxt = sts.n_one ? rmvm_pkg::ST_DONE : rmvm_pkg::ST_DIFF2;
      end
      rmvm_pkg::ST_DIFF2: state_nxt = rmvm_pkg::ST_ABS2;
      rmvm_pkg::ST_ABS2: begin
        cnt_nxt   = CNTW'(K1 - 1);
        state_nxt = rmvm_pkg::ST_MUL;
      end
      rmvm_pkg::ST_MUL: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = rmvm_pkg::ST_CMP;
      end
      rmvm_pkg::ST_CMP: begin
        cnt_nxt   = CNTW'(DW - 1);
        state_nxt = sts.add_neg ? rmvm_pkg::ST_NEG : rmvm_pkg::ST_DIV2;
      end
      rmvm_pkg::ST_NEG: begin
        cnt_nxt   = CNTW'(DW - 1);
        state_nxt = rmvm_pkg::ST_DIV2;
      end
      rmvm_pkg::ST_DIV2: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = rmvm_pkg::ST_VAR;
      end
      rmvm_pkg::ST_VAR: begin
        cnt_nxt   = CNTW'(rmvm_pkg::SQRT_STEPS - 1);
        state_nxt = rmvm_pkg::ST_SQRT;
      end
      rmvm_pkg::ST_SQRT: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = rmvm_pkg::ST_DONE;
      end
      rmvm_pkg::ST_DONE: begin
        if (out_free) state_nxt = rmvm_pkg::ST_IDLE;
      end
      default: state_nxt = rmvm_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready   = (state_r == rmvm_pkg::ST_IDLE);
    ctl.state  = state_r;
    ctl.load   = (state_r == rmvm_pkg::ST_IDLE) && in_valid;
    ctl.commit = (state_r == rmvm_pkg::ST_DONE) && out_free;
    ctl.clear  = clr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmvm_pkg::ST_IDLE;
      cnt_r   <= '0;
      clr_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      clr_r   <= clr_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rmvm_core.sv -----
// Datapath for the running statistics block: statistics registers, working
// registers and the one shared adder. Depends on rmvm_pkg; driven by rmvm_ctrl.
`default_nettype none

module rmvm_core #(
  parameter int COUNT_WIDTH  = rmvm_pkg::COUNT_WIDTH_DEF,
  parameter int SAMPLE_WIDTH = rmvm_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  rmvm_pkg::rmvm_ctl_t                   ctl,
  input  wire signed [SAMPLE_WIDTH-1:0]         sample,
  output rmvm_pkg::rmvm_sts_t                   sts,
  output logic [COUNT_WIDTH-1:0]                sample_count,
  output logic signed [SAMPLE_WIDTH-1:0]        running_mean,
  output logic [rmvm_pkg::VAR_WIDTH-1:0]        running_variance,
  output logic [rmvm_pkg::DEV_WIDTH-1:0]        std_deviation,
  output logic [SAMPLE_WIDTH-2:0]               peak_value
);

  localparam int CW   = COUNT_WIDTH;
  localparam int SW   = SAMPLE_WIDTH;
  localparam int VW   = rmvm_pkg::VAR_WIDTH;
  localparam int DEVW = rmvm_pkg::DEV_WIDTH;
  localparam int DW   = (2 * SW > VW) ? 2 * SW : VW;
  localparam int AW   = ((DW > CW + 1) ? DW : CW + 1) + 2;
  localparam int K1   = SW + 1;

  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
  localparam logic [CW-1:0] CNT_ONE = CW'(1);
  localparam logic [VW-1:0] VAR_MAX = {VW{1'b1}};
  localparam logic [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};

  // Statistics, visible as the result item.
  logic [CW-1:0]   count_r, count_nxt;
  logic [SW-1:0]   mean_r, mean_nxt;
  logic [VW-1:0]   var_r, var_nxt;
  logic [DEVW-1:0] dev_r, dev_nxt;
  logic [SW-2:0]   peak_r, peak_nxt;

  // Working registers of one item.
  logic [SW-1:0] x_r, x_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [AW-1:0] acc_r, acc_nxt;
  logic [DW-1:0] sh_r, sh_nxt;
  logic [AW-1:0] opb_r, opb_nxt;
  logic          neg_r, neg_nxt;
  logic          rnz_r, rnz_nxt;
  logic          ge_r, ge_nxt;
  logic [SW-1:0] mnew_r, mnew_nxt;
  logic [VW-1:0] vnew_r, vnew_nxt;

  // The shared adder.
  logic [AW-1:0] add_a, add_b, add_sum;
  logic          add_inv, add_cin, add_neg;

  logic [AW-1:0] x_ext, mean_ext, mnew_ext, mag;
  logic [CW-1:0] cnt_inc, den;
  logic          acc_nz, mean_in_rng;
  logic [SW-1:0] mean_clamped;
  logic [VW-1:0] var_upd;

  assign add_sum = add_a + (add_inv ? ~add_b : add_b) + AW'(add_cin);
  assign add_neg = add_sum[AW-1];

  assign x_ext    = {{(AW-SW){x_r[SW-1]}}, x_r};
  assign mean_ext = {{(AW-SW){mean_r[SW-1]}}, mean_r};
  assign mnew_ext = {{(AW-SW){mnew_r[SW-1]}}, mnew_r};
  assign mag      = acc_r[AW-1] ? add_sum : acc_r;
  assign acc_nz   = |acc_r;
  assign cnt_inc  = count_r + CNT_ONE;
  assign den      = n_r - CNT_ONE;

  // Saturate the adjusted mean to the sample range.
  assign mean_in_rng  = (&add_sum[AW-1:SW-1]) || !(|add_sum[AW-1:SW-1]);
  assign mean_clamped = mean_in_rng ? add_sum[SW-1:0] :
                        (add_sum[AW-1] ? SMP_MIN : SMP_MAX);

  // Growing variance saturates at the top, shrinking variance floors at zero.
  assign var_upd = ge_r ? ((|add_sum[AW-1:VW]) ? VAR_MAX : add_sum[VW-1:0])
                        : (add_sum[AW-1] ? '0 : add_sum[VW-1:0]);

  assign sts.add_neg = add_neg;
  assign sts.n_one   = (n_r == CNT_ONE);

  // Operand selection for the shared adder.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_inv = 1'b0;
    add_cin = 1'b0;
    case (ctl.state)
      rmvm_pkg::ST_DIFF: begin
        add_a   = x_ext;
        add_b   = mean_ext;
        add_inv = 1'b1;
        add_cin = 1'b1;
      end
      rmvm_pkg::ST_ABS, rmvm_pkg::ST_ABS2, rmvm_pkg::ST_NEG: begin
        add_b   = acc_r;
        add_inv = 1'b1;
        add_cin = 1'b1;
      end
      rmvm_pkg::ST_DIV, rmvm_pkg::ST_DIV2: begin
        add_a   = {acc_r[AW-2:0], sh_r[DW-1]};
        add_b   = opb_r;
        add_inv = 1'b1;
        add_cin = 1'b1;
      end
      rmvm_pkg::ST_MEAN: begin
        // A negative difference rounds the quotient toward minus infinity.
        add_a   = mean_ext;
        add_b   = AW'(sh_r[K1-1:0]);
        add_inv = neg_r;
        add_cin = neg_r && !acc_nz;
      end
      rmvm_pkg::ST_ADJ: begin
        // Pull a negative inexact mean back toward zero.
        add_a   = acc_r;
        add_cin = rnz_r && acc_r[AW-1];
      end
      rmvm_pkg::ST_DIFF2: begin
        add_a   = x_ext;
        add_b   = mnew_ext;
        add_inv = 1'b1;
        add_cin = 1'b1;
      end
      rmvm_pkg::ST_MUL: begin
        add_a = {acc_r[AW-2:0], 1'b0};
        add_b = sh_r[DW-1] ? opb_r : '0;
      end
      rmvm_pkg::ST_CMP: begin
        add_a   = acc_r;
        add_b   = AW'(var_r);
        add_inv = 1'b1;
        add_cin = 1'b1;
      end
      rmvm_pkg::ST_VAR: begin
        // On a decrease the quotient is rounded up: subtract one more when
        // the remainder is nonzero.
        add_a   = AW'(var_r);
        add_b   = AW'(sh_r);
        add_inv = !ge_r;
        add_cin = !ge_r && !acc_nz;
      end
      rmvm_pkg::ST_SQRT: begin
        add_a   = {acc_r[AW-3:0], sh_r[DW-1:DW-2]};
        add_b   = {opb_r[AW-3:0], 2'b01};
        add_inv = 1'b1;
        add_cin = 1'b1;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  // Next values of all registers.
  always_comb begin
    count_nxt = count_r;
    mean_nxt  = mean_r;
    var_nxt   = var_r;
    dev_nxt   = dev_r;
    peak_nxt  = peak_r;
    x_nxt     = x_r;
    n_nxt     = n_r;
    acc_nxt   = acc_r;
    sh_nxt    = sh_r;
    opb_nxt   = opb_r;
    neg_nxt   = neg_r;
    rnz_nxt   = rnz_r;
    ge_nxt    = ge_r;
    mnew_nxt  = mnew_r;
    vnew_nxt  = vnew_r;
    case (ctl.state)
      rmvm_pkg::ST_IDLE: begin
        if (ctl.load) begin
          x_nxt = sample;
          n_nxt = (count_r == CNT_MAX) ? count_r : cnt_inc;
        end
      end
      rmvm_pkg::ST_DIFF, rmvm_pkg::ST_DIFF2, rmvm_pkg::ST_MUL: begin
        acc_nxt = add_sum;
        if (ctl.state == rmvm_pkg::ST_MUL) sh_nxt = {sh_r[DW-2:0], 1'b0};
      end
      rmvm_pkg::ST_ABS: begin
        neg_nxt = acc_r[AW-1];
        sh_nxt  = DW'(mag[K1-1:0]) << (DW - K1);
        acc_nxt = '0;
        opb_nxt = AW'(n_r);
      end
      rmvm_pkg::ST_DIV, rmvm_pkg::ST_DIV2: begin
        acc_nxt = add_neg ? add_a : add_sum;
        sh_nxt  = {sh_r[DW-2:0], !add_neg};
      end
      rmvm_pkg::ST_MEAN: begin
        rnz_nxt = acc_nz;
        acc_nxt = add_sum;
      end
      rmvm_pkg::ST_ADJ: begin
        mnew_nxt = mean_clamped;
        if (n_r == CNT_ONE) begin
          vnew_nxt = '0;
          opb_nxt  = '0;
        end
      end
      rmvm_pkg::ST_ABS2: begin
        opb_nxt = AW'(mag[K1-1:0]);
        sh_nxt  = DW'(mag[K1-1:0]) << (DW - K1);
        acc_nxt = '0;
      end
      rmvm_pkg::ST_CMP: begin
        ge_nxt  = !add_neg;
        opb_nxt = AW'(den);
        if (add_neg) begin
          acc_nxt = add_sum;
        end else begin
          sh_nxt  = add_sum[DW-1:0];
          acc_nxt = '0;
        end
      end
      rmvm_pkg::ST_NEG: begin
        sh_nxt  = add_sum[DW-1:0];
        acc_nxt = '0;
      end
      rmvm_pkg::ST_VAR: begin
        vnew_nxt = var_upd;
        sh_nxt   = DW'(var_upd) << (DW - VW);
        acc_nxt  = '0;
        opb_nxt  = '0;
      end
      rmvm_pkg::ST_SQRT: begin
        acc_nxt = add_neg ? add_a : add_sum;
        opb_nxt = {opb_r[AW-2:0], !add_neg};
        sh_nxt  = {sh_r[DW-3:0], 2'b00};
      end
      rmvm_pkg::ST_DONE: begin
        if (ctl.commit) begin
          if (ctl.clear) begin
            count_nxt = '0;
            mean_nxt  = '0;
            var_nxt   = '0;
            dev_nxt   = '0;
            peak_nxt  = '0;
          end else begin
            count_nxt = n_r;
            mean_nxt  = mnew_r;
            var_nxt   = vnew_r;
            dev_nxt   = opb_r[DEVW-1:0];
            if (!x_r[SW-1] && (x_r[SW-2:0] > peak_r)) peak_nxt = x_r[SW-2:0];
          end
        end
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mean_r  <= '0;
      var_r   <= '0;
      dev_r   <= '0;
      peak_r  <= '0;
    end else begin
      count_r <= count_nxt;
      mean_r  <= mean_nxt;
      var_r   <= var_nxt;
      dev_r   <= dev_nxt;
      peak_r  <= peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    n_r    <= n_nxt;
    acc_r  <= acc_nxt;
    sh_r   <= sh_nxt;
    opb_r  <= opb_nxt;
    neg_r  <= neg_nxt;
    rnz_r  <= rnz_nxt;
    ge_r   <= ge_nxt;
    mnew_r <= mnew_nxt;
    vnew_r <= vnew_nxt;
  end

  assign sample_count     = count_r;
  assign running_mean     = mean_r;
  assign running_variance = var_r;
  assign std_deviation    = dev_r;
  assign peak_value       = peak_r;

endmodule

`default_nettype wire
